// ----- rtl/ryuv_pkg.sv -----
package ryuv_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int DIM_W      = 12;
  localparam int BPP_W      = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH     = 2'd0,
    REG_FRAME_HEIGHT    = 2'd1,
    REG_BYTES_PER_PIXEL = 2'd2,
    REG_SWAP_RED_BLUE   = 2'd3
  } cfg_reg_e;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 12'd2;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 12'd1;
  localparam logic [BPP_W-1:0] BPP_RST    = 3'd4;
  localparam logic [BPP_W-1:0] BPP_FOUR   = 3'd4;
  localparam logic             SWAP_RST   = 1'b1;

  localparam int LUMA_IDX_W   = 22;
  localparam int CHROMA_IDX_W = 20;
  localparam int PIX_W        = 8;
  localparam int IN_TDATA_W   = 8;
  localparam int OUT_PAD_W    = 6;
  localparam int OUT_TDATA_W  = 72;

  // weighted sums before the divide by 100
  localparam int SUM_W = 16;
  localparam int NUM_W = 15;

  localparam logic [SUM_W-1:0] Y_R = 16'd30;
  localparam logic [SUM_W-1:0] Y_G = 16'd59;
  localparam logic [SUM_W-1:0] Y_B = 16'd11;
  localparam logic [SUM_W-1:0] U_R = 16'd17;
  localparam logic [SUM_W-1:0] U_G = 16'd33;
  localparam logic [SUM_W-1:0] U_B = 16'd50;
  localparam logic [SUM_W-1:0] V_R = 16'd50;
  localparam logic [SUM_W-1:0] V_G = 16'd42;
  localparam logic [SUM_W-1:0] V_B = 16'd8;
  localparam logic [SUM_W-1:0] CHROMA_BIAS = 16'd12800;

  // n / 100 == (n * DIV_MUL) >> DIV_SHIFT for n < 43690
  localparam int               DIV_MUL_W = 16;
  localparam logic [DIV_MUL_W-1:0] DIV_MUL = 16'd41944;
  localparam int               DIV_SHIFT = 22;
  localparam int               DIV_PROD_W = NUM_W + DIV_MUL_W;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             chroma_write;
    logic             frame_end;
  } pixel_t;

endpackage

// ----- rtl/rgb_to_yuv420_planar_converter.sv -----
// channel  dir  signals                       payload
// s_axis   in   tvalid tready tdata[7:0]      pixel_byte
// m_axis   out  tvalid tready tdata tuser tlast  luma/chroma indexes and values,
//                                             chroma_write, frame_end
// cfg      in   cfg_valid cfg_ready cfg_index cfg_data  register writes
//
// one byte accepted per clock while s_axis_tready is high; a pixel's sums register
// at the edge that takes its third byte, the divide-by-100 result (reciprocal
// multiply) in the output register behind them; m_axis_tvalid rises as the sum
// stage passes into the output register, and the word leaves with m_axis_tready
// a stalled output word holds; the sum stage holds behind it once full, and then
// s_axis_tready drops
// reset clears the byte phase and counters and loads the register defaults;
// cfg_ready_o is always high
module rgb_to_yuv420_planar_converter #(
  parameter int MAX_WIDTH  = ryuv_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = ryuv_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [ryuv_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // pixel_byte
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // luma_index, luma, chroma_index, chroma_u, chroma_v, zero pad
  output logic [ryuv_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                                m_axis_tuser,  // chroma_write
  output logic                                m_axis_tlast,  // frame_end
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ryuv_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ryuv_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int EW  = ($clog2(MAX_WIDTH) + 1 > ryuv_pkg::DIM_W) ?
                       $clog2(MAX_WIDTH) + 1 : ryuv_pkg::DIM_W;
  localparam int PW  = RW + EW;
  localparam int LIW = ryuv_pkg::LUMA_IDX_W;
  localparam int CIW = ryuv_pkg::CHROMA_IDX_W;
  localparam int SW  = ryuv_pkg::SUM_W;
  localparam int NW  = ryuv_pkg::NUM_W;
  localparam int DPW = ryuv_pkg::DIV_PROD_W;
  localparam int PXW = ryuv_pkg::PIX_W;

  logic              byte_acc, pix_valid, out_adv;
  ryuv_pkg::pixel_t  pix;
  logic [CW-1:0]     col;
  logic [RW-1:0]     row;
  logic [EW-1:0]     width;

  logic [PW-1:0]     luma_idx_full, chroma_idx_full;
  logic [SW-1:0]     r16, g16, b16, y_sum, u_sum, v_sum;

  logic              s1_valid_q;
  logic [LIW-1:0]    s1_luma_idx_q;
  logic [CIW-1:0]    s1_chroma_idx_q;
  logic [NW-1:0]     s1_y_q, s1_u_q, s1_v_q;
  logic              s1_cw_q, s1_last_q;

  logic [DPW-1:0]    y_prod, u_prod, v_prod;

  logic                             out_valid_q;
  logic [ryuv_pkg::OUT_TDATA_W-1:0] out_data_q;
  logic                             out_user_q, out_last_q;

  assign cfg_ready_o   = 1'b1;
  assign out_adv       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || out_adv;
  assign byte_acc      = s_axis_tvalid && s_axis_tready;

  ryuv_pixel_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .byte_valid_i (byte_acc),
    .byte_i       (s_axis_tdata),
    .pix_valid_o  (pix_valid),
    .pix_o        (pix),
    .col_o        (col),
    .row_o        (row),
    .width_o      (width)
  );

  always_comb begin
    luma_idx_full   = PW'(row) * PW'(width) + PW'(col);
    chroma_idx_full = PW'(row >> 1) * PW'(width >> 1) + PW'(col >> 1);
    r16   = SW'(pix.red);
    g16   = SW'(pix.green);
    b16   = SW'(pix.blue);
    y_sum = ryuv_pkg::Y_R * r16 + ryuv_pkg::Y_G * g16 + ryuv_pkg::Y_B * b16;
    u_sum = ryuv_pkg::U_B * b16 + ryuv_pkg::CHROMA_BIAS
          - ryuv_pkg::U_R * r16 - ryuv_pkg::U_G * g16;
    v_sum = ryuv_pkg::V_R * r16 + ryuv_pkg::CHROMA_BIAS
          - ryuv_pkg::V_G * g16 - ryuv_pkg::V_B * b16;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (byte_acc && pix_valid) begin
      s1_valid_q <= 1'b1;
    end else if (out_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_acc && pix_valid) begin
      s1_luma_idx_q   <= LIW'(luma_idx_full);
      s1_chroma_idx_q <= CIW'(chroma_idx_full);
      s1_y_q          <= y_sum[NW-1:0];
      s1_u_q          <= u_sum[NW-1:0];
      s1_v_q          <= v_sum[NW-1:0];
      s1_cw_q         <= pix.chroma_write;
      s1_last_q       <= pix.frame_end;
    end
  end

  always_comb begin
    y_prod = DPW'(s1_y_q) * DPW'(ryuv_pkg::DIV_MUL);
    u_prod = DPW'(s1_u_q) * DPW'(ryuv_pkg::DIV_MUL);
    v_prod = DPW'(s1_v_q) * DPW'(ryuv_pkg::DIV_MUL);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && s1_valid_q) begin
      out_data_q <= {{ryuv_pkg::OUT_PAD_W{1'b0}},
                     v_prod[ryuv_pkg::DIV_SHIFT +: PXW],
                     u_prod[ryuv_pkg::DIV_SHIFT +: PXW],
                     s1_chroma_idx_q,
                     y_prod[ryuv_pkg::DIV_SHIFT +: PXW],
                     s1_luma_idx_q};
      out_user_q <= s1_cw_q;
      out_last_q <= s1_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ----- rtl/ryuv_pixel_seq.sv -----
module ryuv_pixel_seq #(
  parameter int MAX_WIDTH  = ryuv_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = ryuv_pkg::MAX_HEIGHT_DEF,
  localparam int CW  = $clog2(MAX_WIDTH),
  localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
  localparam int EW  = ($clog2(MAX_WIDTH) + 1 > ryuv_pkg::DIM_W) ?
                       $clog2(MAX_WIDTH) + 1 : ryuv_pkg::DIM_W,
  localparam int HEW = ($clog2(MAX_HEIGHT) + 1 > ryuv_pkg::DIM_W) ?
                       $clog2(MAX_HEIGHT) + 1 : ryuv_pkg::DIM_W
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [ryuv_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ryuv_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              byte_valid_i,
  input  logic [ryuv_pkg::PIX_W-1:0]        byte_i,
  output logic                              pix_valid_o,
  output ryuv_pkg::pixel_t                  pix_o,
  output logic [CW-1:0]                     col_o,
  output logic [RW-1:0]                     row_o,
  output logic [EW-1:0]                     width_o
);

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2,
    PH_SKIP   = 2'd3
  } phase_e;

  localparam logic [EW-1:0]  W_MIN = EW'(2);
  localparam logic [EW-1:0]  W_LIM = EW'(MAX_WIDTH);
  localparam logic [EW-1:0]  W_MAX = EW'((MAX_WIDTH / 2) * 2);
  localparam logic [HEW-1:0] H_MIN = HEW'(1);
  localparam logic [HEW-1:0] H_MAX = HEW'(MAX_HEIGHT);

  phase_e                          phase_q;
  logic [ryuv_pkg::PIX_W-1:0]      first_q, second_q;
  logic [CW-1:0]                   col_q;
  logic [RW-1:0]                   row_q;
  logic [ryuv_pkg::DIM_W-1:0]      width_q, height_q;
  logic [ryuv_pkg::BPP_W-1:0]      bpp_q;
  logic                            swap_q;

  logic [EW-1:0]  w_raw, w_eff;
  logic [HEW-1:0] h_raw, h_eff;
  logic [CW-1:0]  col_eff;
  logic [RW-1:0]  row_eff;
  logic           last_col, last_row;

  always_comb begin
    w_raw = EW'({width_q[ryuv_pkg::DIM_W-1:1], 1'b0});
    if (w_raw < W_MIN) begin
      w_eff = W_MIN;
    end else if (w_raw > W_LIM) begin
      w_eff = W_MAX;
    end else begin
      w_eff = w_raw;
    end
    h_raw = HEW'(height_q);
    if (h_raw < H_MIN) begin
      h_eff = H_MIN;
    end else if (h_raw > H_MAX) begin
      h_eff = H_MAX;
    end else begin
      h_eff = h_raw;
    end
    col_eff  = (EW'(col_q) >= w_eff) ? '0 : col_q;
    row_eff  = (HEW'(row_q) >= h_eff) ? '0 : row_q;
    last_col = (EW'(col_eff) + EW'(1)) >= w_eff;
    last_row = (HEW'(row_eff) + HEW'(1)) >= h_eff;
  end

  assign pix_valid_o = byte_valid_i && (phase_q == PH_THIRD);
  assign col_o       = col_eff;
  assign row_o       = row_eff;
  assign width_o     = w_eff;

  always_comb begin
    pix_o.green        = second_q;
    pix_o.red          = swap_q ? byte_i : first_q;
    pix_o.blue         = swap_q ? first_q : byte_i;
    pix_o.chroma_write = col_eff[0];
    pix_o.frame_end    = last_col && last_row;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_FIRST;
      first_q  <= '0;
      second_q <= '0;
      col_q    <= '0;
      row_q    <= '0;
      width_q  <= ryuv_pkg::WIDTH_RST;
      height_q <= ryuv_pkg::HEIGHT_RST;
      bpp_q    <= ryuv_pkg::BPP_RST;
      swap_q   <= ryuv_pkg::SWAP_RST;
    end else begin
      if (cfg_valid_i) begin
        case (ryuv_pkg::cfg_reg_e'(cfg_index_i))
          ryuv_pkg::REG_FRAME_WIDTH:     width_q  <= cfg_data_i;
          ryuv_pkg::REG_FRAME_HEIGHT:    height_q <= cfg_data_i;
          ryuv_pkg::REG_BYTES_PER_PIXEL: bpp_q    <= cfg_data_i[ryuv_pkg::BPP_W-1:0];
          ryuv_pkg::REG_SWAP_RED_BLUE:   swap_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (byte_valid_i) begin
        case (phase_q)
          PH_FIRST: begin
            first_q <= byte_i;
            phase_q <= PH_SECOND;
          end
          PH_SECOND: begin
            second_q <= byte_i;
            phase_q  <= PH_THIRD;
          end
          PH_THIRD: begin
            phase_q <= (bpp_q >= ryuv_pkg::BPP_FOUR) ? PH_SKIP : PH_FIRST;
            if (last_col) begin
              col_q <= '0;
              row_q <= last_row ? '0 : RW'(HEW'(row_eff) + HEW'(1));
            end else begin
              col_q <= CW'(EW'(col_eff) + EW'(1));
              row_q <= row_eff;
            end
          end
          PH_SKIP: phase_q <= PH_FIRST;
          default: phase_q <= PH_FIRST;
        endcase
      end
    end
  end

endmodule

// ----- rtl/ryuv_checker.sv -----
module ryuv_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [ryuv_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input logic                                m_axis_tuser,
  input logic                                m_axis_tlast
);

  // a stalled word keeps its valid and payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  // with an even row width the column parity shows in the luma index
  a_chroma_parity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser == m_axis_tdata[0])
    else $error("chroma write does not match column parity");

  // the last pixel of a frame sits on an odd column
  a_last_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("frame end without chroma write");

  // input only backs up behind a stalled output word
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind rgb_to_yuv420_planar_converter ryuv_checker u_ryuv_checker (.*);
